// ----- design/bsl_pkg.sv -----
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared action and status codes for the bounded sequential list.
// ----------------------------------------------------------------------------
package bsl_pkg;

  localparam int unsigned ActW    = 2;
  localparam int unsigned PosW    = 8;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IdxW    = 7;
  localparam int unsigned CountW  = 8;

  localparam logic [ActW-1:0] ACT_APPEND = 2'd0;
  localparam logic [ActW-1:0] ACT_INSERT = 2'd1;
  localparam logic [ActW-1:0] ACT_FIND   = 2'd2;
  localparam logic [ActW-1:0] ACT_DELETE = 2'd3;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd1;
  localparam logic [StatusW-1:0] ST_BADPOS   = 3'd2;
  localparam logic [StatusW-1:0] ST_EMPTY    = 3'd3;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd4;

endpackage

// ----- design/bsl_ram.sv -----
// ----------------------------------------------------------------------------
// bsl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bounded_sequential_list.sv -----
// Append, tail insert, tail delete and rejected requests (full, empty, bad
// position) go straight to the response state; other inserts, deletes and
// finds first shift or scan the RAM.
// One request in flight at a time; the single RAM read port moves one entry
// per cycle during shifts and scans, which sets the throughput.
// Reset clears the entry count and control state; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
// bounded_sequential_list
// Fixed-capacity ordered list of signed 32-bit words held in a RAM, with
// append, insert, find and delete.
// ----------------------------------------------------------------------------
module bounded_sequential_list #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bsl_pkg::ActW-1:0]          action_i,
  input  logic [bsl_pkg::PosW-1:0]          position_i,
  input  logic signed [bsl_pkg::ValW-1:0]   value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bsl_pkg::StatusW-1:0]       status_o,
  output logic [bsl_pkg::IdxW-1:0]          found_index_o,
  output logic [bsl_pkg::CountW-1:0]        entry_count_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > bsl_pkg::PosW) ? CW : bsl_pkg::PosW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHUP   = 3'd1;
  localparam logic [2:0] S_WRVAL  = 3'd2;
  localparam logic [2:0] S_SHDN   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [AW-1:0]                ptr_q, ptr_d;
  logic [AW-1:0]                pos_q, pos_d;
  logic [bsl_pkg::ValW-1:0]     val_q, val_d;
  logic [bsl_pkg::StatusW-1:0]  res_status_q, res_status_d;
  logic [AW-1:0]                res_idx_q, res_idx_d;

  logic                         out_valid_q;
  logic [bsl_pkg::StatusW-1:0]  out_status_q;
  logic [bsl_pkg::IdxW-1:0]     out_idx_q;
  logic [bsl_pkg::CountW-1:0]   out_cnt_q;

  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [bsl_pkg::ValW-1:0]     mem_wdata, mem_rdata;

  logic                         accept, out_free, is_full, is_empty;
  logic [CMPW-1:0]              pos_ext, cnt_ext, pos_p1;
  logic [CW-1:0]                cnt_m1;
  logic [AW-1:0]                cnt_addr, cnt_m1_addr, last_addr;
  logic [31:0]                  idx_wide, cnt_wide;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign is_full     = (cnt_q == CW'(CAPACITY));
  assign is_empty    = (cnt_q == '0);
  assign pos_ext     = CMPW'(position_i);
  assign cnt_ext     = CMPW'(cnt_q);
  assign pos_p1      = pos_ext + CMPW'(1);
  assign cnt_m1      = cnt_q - CW'(1);
  assign cnt_addr    = cnt_q[AW-1:0];
  assign cnt_m1_addr = cnt_m1[AW-1:0];
  assign last_addr   = cnt_m1[AW-1:0];

  bsl_ram #(
    .WIDTH(bsl_pkg::ValW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    pos_d        = pos_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    mem_we       = 1'b0;
    mem_waddr    = cnt_addr;
    mem_wdata    = value_i;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d        = value_i;
          pos_d        = pos_ext[AW-1:0];
          res_status_d = bsl_pkg::ST_OK;
          res_idx_d    = '0;
          state_d      = S_RESP;
          unique case (action_i)
            bsl_pkg::ACT_APPEND: begin
              if (is_full) begin
                res_status_d = bsl_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_addr;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            bsl_pkg::ACT_INSERT: begin
              if (is_full) begin
                res_status_d = bsl_pkg::ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                res_status_d = bsl_pkg::ST_BADPOS;
              end else if (pos_ext == cnt_ext) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_addr;
                cnt_d     = cnt_q + CW'(1);
              end else begin
                // walk down from the tail, moving each word up one slot
                mem_re    = 1'b1;
                mem_raddr = cnt_m1_addr;
                ptr_d     = cnt_m1_addr;
                state_d   = S_SHUP;
              end
            end
            bsl_pkg::ACT_FIND: begin
              if (is_empty) begin
                res_status_d = bsl_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                ptr_d     = '0;
                state_d   = S_SCAN;
              end
            end
            bsl_pkg::ACT_DELETE: begin
              if (is_empty) begin
                res_status_d = bsl_pkg::ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                res_status_d = bsl_pkg::ST_BADPOS;
              end else if (pos_p1 == cnt_ext) begin
                cnt_d = cnt_m1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_p1[AW-1:0];
                ptr_d     = pos_p1[AW-1:0];
                state_d   = S_SHDN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHUP: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q + AW'(1);
        mem_wdata = mem_rdata;
        if (ptr_q == pos_q) begin
          state_d = S_WRVAL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q - AW'(1);
          ptr_d     = ptr_q - AW'(1);
        end
      end
      S_WRVAL: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
        cnt_d     = cnt_q + CW'(1);
        state_d   = S_RESP;
      end
      S_SHDN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q - AW'(1);
        mem_wdata = mem_rdata;
        if (ptr_q == last_addr) begin
          cnt_d   = cnt_m1;
          state_d = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end
      S_SCAN: begin
        if (mem_rdata == val_q) begin
          res_idx_d = ptr_q;
          state_d   = S_RESP;
        end else if (ptr_q == last_addr) begin
          res_status_d = bsl_pkg::ST_NOTFOUND;
          state_d      = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign idx_wide = 32'(res_idx_q);
  assign cnt_wide = 32'(cnt_q);

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    if (state_q == S_RESP && out_free) begin
      out_status_q <= res_status_q;
      out_idx_q    <= idx_wide[bsl_pkg::IdxW-1:0];
      out_cnt_q    <= cnt_wide[bsl_pkg::CountW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_index_o = out_idx_q;
  assign entry_count_o = out_cnt_q;

endmodule

// ----- design/bsl_checker.sv -----
// ----------------------------------------------------------------------------
// bsl_checker
// Port-level checks for the bounded sequential list, bound to the top level.
// ----------------------------------------------------------------------------
module bsl_checker #(
  parameter int unsigned CAPACITY = 128
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [bsl_pkg::StatusW-1:0]       status_o,
  input logic [bsl_pkg::IdxW-1:0]          found_index_o,
  input logic [bsl_pkg::CountW-1:0]        entry_count_o
);

  logic [31:0] cap_wide;
  assign cap_wide = 32'(CAPACITY);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(found_index_o) && $stable(entry_count_o))
    else $error("stalled result word changed");

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bsl_pkg::ST_OK |-> found_index_o == '0)
    else $error("found index nonzero on failed request");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bsl_pkg::ST_FULL |->
      entry_count_o == cap_wide[bsl_pkg::CountW-1:0])
    else $error("full status with count below capacity");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bsl_pkg::ST_EMPTY |-> entry_count_o == '0)
    else $error("empty status with entries held");

  // one request in flight: the input stalls right after a word is taken
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while a request is in flight");

endmodule

bind bounded_sequential_list bsl_checker #(
  .CAPACITY(CAPACITY)
) u_bsl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .found_index_o(found_index_o),
  .entry_count_o(entry_count_o)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bounded_sequential_list. A directed table covers
// the empty and bad-position paths and the field extremes. Random
// traffic then fills the list to capacity, drains it to empty and mixes all
// actions. Every result word is checked against an in-bench list model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CAPACITY     = 128;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_WORDS = 500;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  typedef struct packed {
    logic [bsl_pkg::StatusW-1:0] status;
    logic [bsl_pkg::IdxW-1:0]    idx;
    logic [bsl_pkg::CountW-1:0]  count;
  } list_reply_t;

  typedef struct packed {
    logic [bsl_pkg::ActW-1:0] act;
    logic [bsl_pkg::PosW-1:0] pos;
    logic [bsl_pkg::ValW-1:0] val;
    logic                     typed;
    list_reply_t              want;
  } plan_row_t;

  localparam int PLAN_ROWS = 24;

  // typed rows carry their own expected word; the rest use the list model
  plan_row_t plan [PLAN_ROWS] = '{
    '{bsl_pkg::ACT_FIND,   8'd0,   32'd0,         1'b1, '{bsl_pkg::ST_EMPTY,  7'd0, 8'd0}},
    '{bsl_pkg::ACT_DELETE, 8'd0,   32'd0,         1'b1, '{bsl_pkg::ST_EMPTY,  7'd0, 8'd0}},
    '{bsl_pkg::ACT_DELETE, 8'd255, 32'd0,         1'b1, '{bsl_pkg::ST_EMPTY,  7'd0, 8'd0}},
    '{bsl_pkg::ACT_INSERT, 8'd1,   32'd1,         1'b1, '{bsl_pkg::ST_BADPOS, 7'd0, 8'd0}},
    '{bsl_pkg::ACT_INSERT, 8'd255, 32'd1,         1'b1, '{bsl_pkg::ST_BADPOS, 7'd0, 8'd0}},
    '{bsl_pkg::ACT_INSERT, 8'd0,   32'h8000_0000, 1'b1, '{bsl_pkg::ST_OK,     7'd0, 8'd1}},
    '{bsl_pkg::ACT_APPEND, 8'd0,   32'h7FFF_FFFF, 1'b1, '{bsl_pkg::ST_OK,     7'd0, 8'd2}},
    '{bsl_pkg::ACT_APPEND, 8'd255, 32'd0,         1'b1, '{bsl_pkg::ST_OK,     7'd0, 8'd3}},
    '{bsl_pkg::ACT_APPEND, 8'd0,   32'hFFFF_FFFF, 1'b1, '{bsl_pkg::ST_OK,     7'd0, 8'd4}},
    '{bsl_pkg::ACT_INSERT, 8'd4,   32'd5,         1'b0, '0},
    '{bsl_pkg::ACT_INSERT, 8'd2,   32'd7,         1'b0, '0},
    '{bsl_pkg::ACT_INSERT, 8'd0,   32'd7,         1'b0, '0},
    '{bsl_pkg::ACT_FIND,   8'd0,   32'd7,         1'b0, '0},
    '{bsl_pkg::ACT_FIND,   8'd0,   32'h7FFF_FFFF, 1'b0, '0},
    '{bsl_pkg::ACT_FIND,   8'd0,   32'h8000_0000, 1'b0, '0},
    '{bsl_pkg::ACT_FIND,   8'd0,   32'd12345,     1'b1, '{bsl_pkg::ST_NOTFOUND, 7'd0, 8'd7}},
    '{bsl_pkg::ACT_FIND,   8'd255, 32'hFFFF_FFFF, 1'b0, '0},
    '{bsl_pkg::ACT_DELETE, 8'd7,   32'd0,         1'b1, '{bsl_pkg::ST_BADPOS, 7'd0, 8'd7}},
    '{bsl_pkg::ACT_INSERT, 8'd8,   32'd9,         1'b1, '{bsl_pkg::ST_BADPOS, 7'd0, 8'd7}},
    '{bsl_pkg::ACT_DELETE, 8'd0,   32'd0,         1'b0, '0},
    '{bsl_pkg::ACT_DELETE, 8'd5,   32'd0,         1'b0, '0},
    '{bsl_pkg::ACT_DELETE, 8'd2,   32'd0,         1'b0, '0},
    '{bsl_pkg::ACT_FIND,   8'd0,   32'd7,         1'b0, '0},
    '{bsl_pkg::ACT_APPEND, 8'd0,   32'd7,         1'b0, '0}
  };

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic [bsl_pkg::ActW-1:0]             action_i;
  logic [bsl_pkg::PosW-1:0]             position_i;
  logic signed [bsl_pkg::ValW-1:0]      value_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i;
  logic [bsl_pkg::StatusW-1:0]          status_o;
  logic [bsl_pkg::IdxW-1:0]             found_index_o;
  logic [bsl_pkg::CountW-1:0]           entry_count_o;

  logic [bsl_pkg::ValW-1:0] list_mem [CAPACITY];
  int              list_len = 0;
  list_reply_t     reply_q [$];
  int              fail_cnt = 0;
  int              idle_cycles = 0;
  bit              calm = 1'b0;

  bounded_sequential_list #(.CAPACITY(CAPACITY)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .entry_count_o(entry_count_o)
  );

  always #1 clk_i = ~clk_i;

  // list model: applies one action and returns the word it produces
  function automatic list_reply_t apply_action(logic [bsl_pkg::ActW-1:0] act,
                                               logic [bsl_pkg::PosW-1:0] pos,
                                               logic [bsl_pkg::ValW-1:0] val);
    list_reply_t r;
    int k;
    r = '0;
    r.status = bsl_pkg::ST_OK;
    case (act)
      bsl_pkg::ACT_APPEND: begin
        if (list_len >= CAPACITY) r.status = bsl_pkg::ST_FULL;
        else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      bsl_pkg::ACT_INSERT: begin
        if (list_len >= CAPACITY) r.status = bsl_pkg::ST_FULL;
        else if (int'(pos) > list_len) r.status = bsl_pkg::ST_BADPOS;
        else begin
          for (k = list_len; k > int'(pos); k--) list_mem[k] = list_mem[k-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      bsl_pkg::ACT_FIND: begin
        if (list_len == 0) r.status = bsl_pkg::ST_EMPTY;
        else begin
          r.status = bsl_pkg::ST_NOTFOUND;
          // walk down so the lowest match wins
          for (k = list_len - 1; k >= 0; k--) begin
            if (list_mem[k] == val) begin
              r.status = bsl_pkg::ST_OK;
              r.idx = k[bsl_pkg::IdxW-1:0];
            end
          end
        end
      end
      default: begin
        if (list_len == 0) r.status = bsl_pkg::ST_EMPTY;
        else if (int'(pos) >= list_len) r.status = bsl_pkg::ST_BADPOS;
        else begin
          for (k = int'(pos); k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end
      end
    endcase
    r.count = list_len[bsl_pkg::CountW-1:0];
    return r;
  endfunction

  function automatic logic [bsl_pkg::ValW-1:0] rand_value();
    int roll;
    roll = $urandom_range(99);
    // small values give plenty of duplicates for find
    if (roll < 40) return 32'($urandom_range(16)) - 32'd8;
    if (roll < 85) return $urandom;
    case (roll % 4)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic pick_word(int mode, output logic [bsl_pkg::ActW-1:0] act,
                           output logic [bsl_pkg::PosW-1:0] pos,
                           output logic [bsl_pkg::ValW-1:0] val);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      MODE_FILL:
        act = roll < 45 ? bsl_pkg::ACT_APPEND : roll < 85 ? bsl_pkg::ACT_INSERT :
              roll < 95 ? bsl_pkg::ACT_FIND : bsl_pkg::ACT_DELETE;
      MODE_DRAIN:
        act = roll < 80 ? bsl_pkg::ACT_DELETE : roll < 90 ? bsl_pkg::ACT_FIND :
              roll < 95 ? bsl_pkg::ACT_APPEND : bsl_pkg::ACT_INSERT;
      default:
        act = 2'($urandom_range(3));
    endcase
    roll = $urandom_range(99);
    if (act == bsl_pkg::ACT_DELETE && list_len > 0 && roll < 85)
      pos = 8'($urandom_range(list_len - 1));
    else if (act != bsl_pkg::ACT_DELETE && roll < 85) pos = 8'($urandom_range(list_len));
    else if (roll < 90) pos = list_len[bsl_pkg::PosW-1:0];
    else pos = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (act == bsl_pkg::ACT_FIND && list_len > 0 && roll < 50)
      val = list_mem[$urandom_range(list_len - 1)];
    else val = rand_value();
  endtask

  task automatic drive_word(logic [bsl_pkg::ActW-1:0] act, logic [bsl_pkg::PosW-1:0] pos,
                            logic [bsl_pkg::ValW-1:0] val,
                            logic typed = 1'b0, list_reply_t want = '0);
    list_reply_t pred;
    while (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = apply_action(act, pos, val);
    reply_q.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_fail(string msg);
    if (fail_cnt < 10) $display("[%0t] MISMATCH %s", $realtime, msg);
    fail_cnt++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) note_fail($sformatf("%s: expected %0d, got %0d", name, want, got));
  endtask

  initial begin
    logic [bsl_pkg::ActW-1:0] act;
    logic [bsl_pkg::PosW-1:0] pos;
    logic [bsl_pkg::ValW-1:0] val;
    int n;
    int mix_n;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = bsl_pkg::ACT_APPEND;
    position_i  = '0;
    value_i     = '0;
    out_stall_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i])
      drive_word(plan[i].act, plan[i].pos, plan[i].val, plan[i].typed, plan[i].want);
    wait_drained();

    n = 0;
    while (list_len < CAPACITY && n < 1000) begin
      calm = (n >= 120 && n < 200);
      pick_word(MODE_FILL, act, pos, val);
      drive_word(act, pos, val);
      n++;
    end
    calm = 1'b0;
    // full list: insert past the end still reports full
    drive_word(bsl_pkg::ACT_INSERT, 8'd128, rand_value());
    drive_word(bsl_pkg::ACT_APPEND, 8'd0, rand_value());
    drive_word(bsl_pkg::ACT_INSERT, 8'd0, rand_value());
    n += 3;
    repeat (6) begin
      pick_word(MODE_MIX, act, pos, val);
      drive_word(act, pos, val);
      n++;
    end
    wait_drained();

    while (list_len > 0 && n < 1500) begin
      pick_word(MODE_DRAIN, act, pos, val);
      drive_word(act, pos, val);
      n++;
    end
    wait_drained();

    mix_n = 0;
    while (n < RANDOM_WORDS || mix_n < 60) begin
      pick_word(MODE_MIX, act, pos, val);
      drive_word(act, pos, val);
      n++;
      mix_n++;
    end
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) $display("bounded_sequential_list verification clean");
    else $display("bounded_sequential_list verification failed");
    $finish;
  end

  always @(posedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 18);

  always @(posedge clk_i) begin
    list_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reply_q.size() == 0) begin
        note_fail($sformatf("unexpected word: status %0d index %0d count %0d",
                            status_o, found_index_o, entry_count_o));
      end else begin
        want = reply_q.pop_front();
        check_field("status", 8'(status_o), 8'(want.status));
        check_field("found_index", 8'(found_index_o), 8'(want.idx));
        check_field("entry_count", 8'(entry_count_o), 8'(want.count));
      end
    end
  end

  // no word moving on either side for too long means the block hung
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("bounded_sequential_list verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
